// ===== rtl/cepstral_delta_feature_defines.svh =====
// Assertion macros for the cepstral delta feature block.
// Used by the port-level checker; expects clk_i and rst_ni in scope.
`ifndef CEPSTRAL_DELTA_FEATURE_DEFINES_SVH
`define CEPSTRAL_DELTA_FEATURE_DEFINES_SVH

// pre holds at an edge, post must hold at the next one
`define CDF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("cdf checker: next-cycle property failed");

// pre and post at the same edge
`define CDF_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("cdf checker: same-cycle property failed");

`endif

// ===== rtl/cdf_pkg.sv =====
// Shared constants and types of the cepstral delta feature block.
// No dependencies.
`default_nettype none

package cdf_pkg;

  localparam int MAX_COEFS_DEF  = 16;
  localparam int COEF_WIDTH_DEF = 16;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] COEF_COUNT_RST = 5'd13;

  localparam int FRAME_W     = 16;
  localparam int RING_FRAMES = 4;
  localparam int DELTA_SPAN  = 2;
  localparam int SLOT_W      = 2;

  // fill count saturates one past the ring depth
  localparam int FILL_W   = 3;
  localparam int FILL_MAX = RING_FRAMES + 1;

  // back offset of a result: 0 is the incoming frame, 1..4 are ring frames
  localparam int OFF_W   = 3;
  localparam int N_VALS  = RING_FRAMES + 1;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [OFF_W-1:0] first_off;
    logic [OFF_W-1:0] last_off;
    logic             frame_done;
  } job_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/cdf_in_if.sv =====
// Input channel of the cepstral delta feature block: one coefficient per transaction.
// Depends on cdf_pkg.
`default_nettype none

interface cdf_in_if #(
  parameter int COEF_WIDTH = cdf_pkg::COEF_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_value;
  logic                         in_last_frame;

  modport source (output valid, coef_value, in_last_frame, input ready);
  modport sink   (input valid, coef_value, in_last_frame, output ready);
endinterface

`default_nettype wire

// ===== rtl/cdf_out_if.sv =====
// Result channel of the cepstral delta feature block.
// Depends on cdf_pkg.
`default_nettype none

interface cdf_out_if #(
  parameter int COEF_WIDTH = cdf_pkg::COEF_WIDTH_DEF,
  parameter int IDX_W      = (cdf_pkg::MAX_COEFS_DEF > 1) ? $clog2(cdf_pkg::MAX_COEFS_DEF) : 1
);
  logic                            valid;
  logic                            ready;
  logic [cdf_pkg::FRAME_W-1:0]     frame_number;
  logic [IDX_W-1:0]                coef_index;
  logic signed [COEF_WIDTH-1:0]    cep_value;
  logic signed [COEF_WIDTH:0]      delta_value;
  logic                            frame_done;
  logic                            burst_last;

  modport source (output valid, frame_number, coef_index, cep_value, delta_value,
                  frame_done, burst_last, input ready);
  modport sink   (input valid, frame_number, coef_index, cep_value, delta_value,
                  frame_done, burst_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/cdf_cfg_if.sv =====
// Configuration write channel: carries the coefficient count register.
// Depends on cdf_pkg.
`default_nettype none

interface cdf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cdf_pkg::CFG_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cdf_front.sv =====
// Front end: coefficient position and frame tracking, four-bank frame ring,
// and classification of each coefficient into a job of results. Uses cdf_pkg.
`default_nettype none

module cdf_front #(
  parameter int  MAX_COEFS  = cdf_pkg::MAX_COEFS_DEF,
  parameter int  COEF_WIDTH = cdf_pkg::COEF_WIDTH_DEF,
  localparam int IdxW       = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_valid_i,
  input  logic [cdf_pkg::CFG_W-1:0]                     cfg_data_i,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic [COEF_WIDTH-1:0]                         coef_value_i,
  input  logic                                          in_last_frame_i,
  output logic                                          job_valid_o,
  input  logic                                          job_ready_i,
  output cdf_pkg::job_ctrl_t                            job_ctrl_o,
  output logic [cdf_pkg::FRAME_W-1:0]                   job_frame_o,
  output logic [IdxW-1:0]                               job_idx_o,
  output logic [COEF_WIDTH:0]                           job_delta_o,
  output logic [cdf_pkg::N_VALS-1:0][COEF_WIDTH-1:0]    job_vals_o
);
  import cdf_pkg::*;

  logic [CFG_W-1:0]   count_q;
  logic [IdxW-1:0]    pos_q, pos_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [FILL_W-1:0]  fill_q, fill_d;

  logic [IdxW-1:0]    last_idx;
  logic [IdxW-1:0]    cidx;
  logic               end_item;
  logic               accept;
  logic               full_ring;
  logic               has_res;
  job_ctrl_t          ctrl;

  logic               s1_valid_q, s1_valid_d;
  job_ctrl_t          s1_ctrl_q;
  logic [FRAME_W-1:0] s1_frame_q;
  logic [IdxW-1:0]    s1_idx_q;
  logic [COEF_WIDTH-1:0] s1_x_q;
  logic [SLOT_W-1:0]  s1_slot_q;
  logic               s1_zero_q;

  logic [COEF_WIDTH-1:0] rd_q [RING_FRAMES];
  logic [COEF_WIDTH:0]   x_ext, r4_ext;

  // clamp the configured count into 1..MAX_COEFS
  always_comb begin
    if (count_q == '0) begin
      last_idx = '0;
    end else if (int'(count_q) > MAX_COEFS) begin
      last_idx = IdxW'(MAX_COEFS - 1);
    end else begin
      last_idx = IdxW'(count_q - 1'b1);
    end
  end

  assign cidx      = (pos_q > last_idx) ? last_idx : pos_q;
  assign end_item  = (cidx == last_idx);
  assign in_ready_o = !s1_valid_q || job_ready_i;
  assign accept    = in_valid_i && in_ready_o;
  assign full_ring = (fill_q >= FILL_W'(RING_FRAMES));
  assign has_res   = full_ring || in_last_frame_i;

  always_comb begin
    ctrl.frame_done = end_item;
    if (full_ring) begin
      ctrl.first_off = (fill_q == FILL_W'(RING_FRAMES)) ? OFF_W'(RING_FRAMES)
                                                        : OFF_W'(DELTA_SPAN);
      ctrl.last_off  = in_last_frame_i ? '0 : OFF_W'(DELTA_SPAN);
    end else begin
      ctrl.first_off = OFF_W'(fill_q);
      ctrl.last_off  = '0;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    slot_d  = slot_q;
    frame_d = frame_q;
    fill_d  = fill_q;
    if (accept) begin
      if (end_item) begin
        pos_d = '0;
        if (in_last_frame_i) begin
          slot_d  = '0;
          frame_d = '0;
          fill_d  = '0;
        end else begin
          slot_d  = slot_q + 1'b1;
          frame_d = frame_q + 1'b1;
          if (fill_q < FILL_W'(FILL_MAX)) begin
            fill_d = fill_q + 1'b1;
          end
        end
      end else begin
        pos_d = cidx + 1'b1;
      end
    end
  end

  always_comb begin
    if (accept) begin
      s1_valid_d = has_res;
    end else if (job_ready_i) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= COEF_COUNT_RST;
      pos_q      <= '0;
      slot_q     <= '0;
      frame_q    <= '0;
      fill_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
      pos_q      <= pos_d;
      slot_q     <= slot_d;
      frame_q    <= frame_d;
      fill_q     <= fill_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctrl_q  <= ctrl;
      s1_frame_q <= frame_q;
      s1_idx_q   <= cidx;
      s1_x_q     <= coef_value_i;
      s1_slot_q  <= slot_q;
      s1_zero_q  <= !full_ring;
    end
  end

  // one bank per ring slot; read all banks at the coefficient, write the current slot.
  // the bank of the current slot returns its old contents: the frame four back.
  for (genvar b = 0; b < RING_FRAMES; b++) begin : g_bank
    logic [COEF_WIDTH-1:0] bank_mem [MAX_COEFS];

    always_ff @(posedge clk_i) begin
      if (accept) begin
        if (slot_q == SLOT_W'(b)) begin
          bank_mem[cidx] <= coef_value_i;
        end
        rd_q[b] <= bank_mem[cidx];
      end
    end
  end

  assign job_vals_o[0] = s1_x_q;
  for (genvar j = 1; j < N_VALS; j++) begin : g_vals
    assign job_vals_o[j] = rd_q[s1_slot_q - SLOT_W'(j)];
  end

  assign x_ext  = {s1_x_q[COEF_WIDTH-1], s1_x_q};
  assign r4_ext = {rd_q[s1_slot_q][COEF_WIDTH-1], rd_q[s1_slot_q]};

  assign job_valid_o = s1_valid_q;
  assign job_ctrl_o  = s1_ctrl_q;
  assign job_frame_o = s1_frame_q;
  assign job_idx_o   = s1_idx_q;
  assign job_delta_o = s1_zero_q ? '0 : (x_ext - r4_ext);

endmodule

`default_nettype wire

// ===== rtl/cdf_queue.sv =====
// Short register queue between the front and back ends.
// Depends on nothing but its parameters.
`default_nettype none

module cdf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cdf_back.sv =====
// Back end: walks the results of each job into the output register, one per
// cycle unless the output stalls. Uses cdf_pkg.
`default_nettype none

module cdf_back #(
  parameter int COEF_WIDTH = cdf_pkg::COEF_WIDTH_DEF,
  parameter int IDX_W      = 4
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          job_valid_i,
  output logic                                          job_ready_o,
  input  cdf_pkg::job_ctrl_t                            job_ctrl_i,
  input  logic [cdf_pkg::FRAME_W-1:0]                   job_frame_i,
  input  logic [IDX_W-1:0]                              job_idx_i,
  input  logic [COEF_WIDTH:0]                           job_delta_i,
  input  logic [cdf_pkg::N_VALS-1:0][COEF_WIDTH-1:0]    job_vals_i,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output logic [cdf_pkg::FRAME_W-1:0]                   frame_number_o,
  output logic [IDX_W-1:0]                              coef_index_o,
  output logic [COEF_WIDTH-1:0]                         cep_value_o,
  output logic [COEF_WIDTH:0]                           delta_value_o,
  output logic                                          frame_done_o,
  output logic                                          burst_last_o
);
  import cdf_pkg::*;

  logic             out_valid_q;
  logic             mid_q;
  logic [OFF_W-1:0] off_q;
  logic [OFF_W-1:0] cur_off;
  logic             load;
  logic             job_end;

  logic [FRAME_W-1:0]    frame_q;
  logic [IDX_W-1:0]      idx_q;
  logic [COEF_WIDTH-1:0] cep_q;
  logic [COEF_WIDTH:0]   delta_q;
  logic                  done_q;
  logic                  last_q;

  // offsets count down: results leave in ascending frame order
  assign cur_off     = mid_q ? off_q : job_ctrl_i.first_off;
  assign load        = job_valid_i && (!out_valid_q || out_ready_i);
  assign job_end     = (cur_off == job_ctrl_i.last_off);
  assign job_ready_o = load && job_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mid_q       <= 1'b0;
      off_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        mid_q       <= !job_end;
        off_q       <= cur_off - 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= job_frame_i - FRAME_W'(cur_off);
      idx_q   <= job_idx_i;
      cep_q   <= job_vals_i[cur_off];
      delta_q <= job_delta_i;
      done_q  <= job_ctrl_i.frame_done;
      last_q  <= job_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_number_o = frame_q;
  assign coef_index_o   = idx_q;
  assign cep_value_o    = cep_q;
  assign delta_value_o  = delta_q;
  assign frame_done_o   = done_q;
  assign burst_last_o   = last_q;

endmodule

`default_nettype wire

// ===== rtl/cepstral_delta_feature.sv =====
// Cepstral delta feature block: top level tying front end, queue and back end.
// Depends on cdf_pkg, cdf_in_if, cdf_out_if, cdf_cfg_if, cdf_front, cdf_queue, cdf_back.
//
// Coefficients come in one per transaction, frame after frame; for coefficient c
// of frame f the block emits frame f-2 with delta x[f][c] - x[f-4][c], kept
// exact in COEF_WIDTH+1 bits. Every item of the fifth frame also emits frames
// 0 and 1 with that delta, and each item of the final frame (in_last_frame set)
// also emits frames n-2 and n-1; utterances under five frames emit all frames
// on their final frame with zero delta. Throughput is one item per cycle while
// each item yields at most one result and the output does not stall; an item
// with k results (up to five, only at utterance edges) holds the single output
// register while they leave, and the two-entry job queue absorbs short output
// stalls. The ring is four single-port banks of MAX_COEFS entries, all read at
// the coefficient index in the cycle an item is taken. Configuration is always
// ready; the user must write it only while idle; the block does not enforce it.

`default_nettype none

module cepstral_delta_feature #(
  parameter int MAX_COEFS  = cdf_pkg::MAX_COEFS_DEF,
  parameter int COEF_WIDTH = cdf_pkg::COEF_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdf_cfg_if.sink    cfg_i,
  cdf_in_if.sink     in_i,
  cdf_out_if.source  out_o
);
  import cdf_pkg::*;

  localparam int IdxW = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
  localparam int JobW = $bits(job_ctrl_t) + FRAME_W + IdxW + (COEF_WIDTH + 1)
                        + N_VALS * COEF_WIDTH;

  logic                               f_valid, f_ready;
  job_ctrl_t                          f_ctrl, b_ctrl;
  logic [FRAME_W-1:0]                 f_frame, b_frame;
  logic [IdxW-1:0]                    f_idx, b_idx;
  logic [COEF_WIDTH:0]                f_delta, b_delta;
  logic [N_VALS-1:0][COEF_WIDTH-1:0]  f_vals, b_vals;
  logic                               b_valid, b_ready;
  logic [JobW-1:0]                    q_in, q_out;

  assign cfg_i.ready = 1'b1;

  cdf_front #(
    .MAX_COEFS  (MAX_COEFS),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_data_i      (cfg_i.data),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .coef_value_i    (in_i.coef_value),
    .in_last_frame_i (in_i.in_last_frame),
    .job_valid_o     (f_valid),
    .job_ready_i     (f_ready),
    .job_ctrl_o      (f_ctrl),
    .job_frame_o     (f_frame),
    .job_idx_o       (f_idx),
    .job_delta_o     (f_delta),
    .job_vals_o      (f_vals)
  );

  assign q_in = {f_ctrl, f_frame, f_idx, f_delta, f_vals};
  assign {b_ctrl, b_frame, b_idx, b_delta, b_vals} = q_out;

  cdf_queue #(
    .WIDTH (JobW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (q_in),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_out)
  );

  cdf_back #(
    .COEF_WIDTH (COEF_WIDTH),
    .IDX_W      (IdxW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (b_valid),
    .job_ready_o    (b_ready),
    .job_ctrl_i     (b_ctrl),
    .job_frame_i    (b_frame),
    .job_idx_i      (b_idx),
    .job_delta_i    (b_delta),
    .job_vals_i     (b_vals),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .frame_number_o (out_o.frame_number),
    .coef_index_o   (out_o.coef_index),
    .cep_value_o    (out_o.cep_value),
    .delta_value_o  (out_o.delta_value),
    .frame_done_o   (out_o.frame_done),
    .burst_last_o   (out_o.burst_last)
  );

endmodule

`default_nettype wire

// ===== rtl/cdf_checker.sv =====
// Port-level checker for the cepstral delta feature block, bound to the top level.
// Depends on cepstral_delta_feature_defines.svh.
`default_nettype none

`include "cepstral_delta_feature_defines.svh"

module cdf_checker #(
  parameter int COEF_WIDTH = 16,
  parameter int IDX_W      = 4
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [15:0]           out_frame,
  input logic [IDX_W-1:0]      out_idx,
  input logic [COEF_WIDTH-1:0] out_cep,
  input logic                  out_burst_last
);

  // handshake: a stalled result stays and holds its frame and value
  `CDF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CDF_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                   $stable(out_frame) && $stable(out_cep))

  // a burst continues without a gap, on the same coefficient
  `CDF_ASSERT_NEXT(a_burst_cont, out_valid && out_ready && !out_burst_last,
                   out_valid && $stable(out_idx))

  // frames within a burst ascend one at a time
  `CDF_ASSERT_NEXT(a_burst_frames, out_valid && out_ready && !out_burst_last,
                   out_frame == 16'($past(out_frame) + 16'd1))

endmodule

bind cepstral_delta_feature cdf_checker #(
  .COEF_WIDTH (COEF_WIDTH),
  .IDX_W      (IdxW)
) u_cdf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .out_frame      (out_o.frame_number),
  .out_idx        (out_o.coef_index),
  .out_cep        (out_o.cep_value),
  .out_burst_last (out_o.burst_last)
);

`default_nettype wire
